FILE: rtl/hlos_pkg.sv
// ----------------------------------------------------------------------------
// hlos_pkg
// Shared widths, codes and types for the height field line-of-sight block.
// ----------------------------------------------------------------------------
package hlos_pkg;

	// field widths
	localparam int COL_W = 10;
	localparam int HGT_W = 11;
	localparam int Z_W   = 12;
	localparam int GND_W = 11;
	// march length: max(|dx|,|dz|) is at most 4095
	localparam int MD_W  = 12;

	localparam logic [GND_W-1:0] GROUND_RESET = GND_W'(200);

	// request codes
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_TAIL,
		ST_FIN
	} state_t;

	// control for one quotient stepper
	typedef struct packed {
		logic init;
		logic adv;
	} step_ctl_t;

endpackage

FILE: rtl/hlos_req_if.sv
// ----------------------------------------------------------------------------
// hlos_req_if
// Request channel: height writes and shadow queries.
// ----------------------------------------------------------------------------
interface hlos_req_if;
	logic                                valid;
	logic                                ready;
	logic                                action;
	logic        [hlos_pkg::COL_W-1:0]   column;
	logic signed [hlos_pkg::HGT_W-1:0]   height;
	logic        [hlos_pkg::COL_W-1:0]   point_x;
	logic signed [hlos_pkg::Z_W-1:0]     point_z;
	logic        [hlos_pkg::COL_W-1:0]   light_x;
	logic signed [hlos_pkg::Z_W-1:0]     light_z;

	modport source (
		output valid, action, column, height, point_x, point_z, light_x, light_z,
		input  ready
	);
	modport sink (
		input  valid, action, column, height, point_x, point_z, light_x, light_z,
		output ready
	);
endinterface

FILE: rtl/hlos_rsp_if.sv
// ----------------------------------------------------------------------------
// hlos_rsp_if
// Response channel: one shadow flag per query.
// ----------------------------------------------------------------------------
interface hlos_rsp_if;
	logic valid;
	logic ready;
	logic shadowed;

	modport source (
		output valid, shadowed,
		input  ready
	);
	modport sink (
		input  valid, shadowed,
		output ready
	);
endinterface

FILE: rtl/hlos_step.sv
// ----------------------------------------------------------------------------
// hlos_step
// Running quotient of n*num/md for n = 0,1,2,... without a divider.
// ----------------------------------------------------------------------------
module hlos_step (
	input  logic                            clk,
	input  hlos_pkg::step_ctl_t             ctl,
	input  logic [hlos_pkg::MD_W-1:0]       num,
	input  logic [hlos_pkg::MD_W-1:0]       md,
	output logic [hlos_pkg::MD_W-1:0]       q
);

	logic [hlos_pkg::MD_W-1:0] q_q;
	logic [hlos_pkg::MD_W-1:0] r_q;
	logic [hlos_pkg::MD_W:0]   sum;
	logic                      wrap;
	logic [hlos_pkg::MD_W:0]   r_next;

	// num <= md and r < md, so one subtract keeps the remainder below md
	always_comb begin
		sum    = {1'b0, r_q} + {1'b0, num};
		wrap   = (sum >= {1'b0, md});
		r_next = wrap ? (sum - {1'b0, md}) : sum;
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			q_q <= '0;
			r_q <= '0;
		end else if (ctl.adv) begin
			r_q <= r_next[hlos_pkg::MD_W-1:0];
			q_q <= q_q + hlos_pkg::MD_W'(wrap);
		end
	end

	assign q = q_q;

endmodule

FILE: rtl/heightfield_line_of_sight_core.sv
// ----------------------------------------------------------------------------
// heightfield_line_of_sight_core
// Shadow test over a column height map held in one on-chip memory.
//
// req carries write requests (action 0: column, height) and query requests
// (action 1: point and light). A write is stored in the cycle it is taken
// and gives no response. A query marches the line from the point toward the
// light, one sample per cycle, reading the height of each sample column from
// the memory; rsp returns one shadowed flag per query.
// A query with md = max(|dx|,|dz|) holds req.ready low through setup, up
// to md samples, a tail state and the loading of its response, stopping
// early once a sample is blocked; the single memory read port allows one
// sample per cycle. Writes never hold req.ready low. ground_level is
// loaded through cfg_we / cfg_wdata. After reset the memory is cleared
// to zero, one entry per cycle, while req.ready stays low; ground_level
// resets to 200. rsp has an output register: a new request is taken while
// a response waits, and a query only stalls at its end if rsp is still held.
// ----------------------------------------------------------------------------
module heightfield_line_of_sight_core #(
	parameter int COLUMNS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	hlos_req_if.sink                      req,
	hlos_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [hlos_pkg::GND_W-1:0]    cfg_wdata
);

	localparam int AW = $clog2(COLUMNS);
	localparam int XW = 13;
	localparam logic [XW-1:0] COL_LIMIT = XW'(COLUMNS);
	localparam logic [AW-1:0] CLR_LAST  = AW'(COLUMNS - 1);

	localparam int MW = hlos_pkg::MD_W;
	localparam int HW = hlos_pkg::HGT_W;
	localparam int CW = hlos_pkg::COL_W;

	hlos_pkg::state_t state_q, state_d;

	logic [hlos_pkg::GND_W-1:0] ground_q;
	logic [AW-1:0]              clr_q;

	// query operands
	logic        [CW-1:0] px_q;
	logic signed [12:0]   pz_q;
	logic signed [CW:0]   dx_q;
	logic signed [12:0]   dz_q;
	logic [MW-1:0]        adx_q, adz_q, md_q, n_q;
	logic                 xneg_q, zneg_q;
	logic                 res_q;

	// response register
	logic out_valid_q, out_shadow_q;

	// memory and sample stage
	logic [HW-1:0]        mem [COLUMNS];
	logic [HW-1:0]        rd_q;
	logic signed [12:0]   z_s1;
	logic                 inr_s1;
	logic                 v_s1;

	// control
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [HW-1:0]        mem_wdata;
	logic                 issue;
	logic                 res_set, res_clr, load_out;
	hlos_pkg::step_ctl_t  step_ctl;

	// combinational helpers
	logic signed [CW:0]   dx_in;
	logic signed [12:0]   dz_in;
	logic [CW:0]          adx;
	logic [12:0]          adz;
	logic [MW-1:0]        adx_w, adz_w, md_w;
	logic [XW-1:0]        wcol_wide;
	logic                 wcol_ok;
	logic [MW-1:0]        qx, qz;
	logic [CW:0]          col_sum;
	logic [XW-1:0]        col_wide;
	logic signed [12:0]   z_smp;
	logic [HW-1:0]        hgt;
	logic signed [12:0]   surf;
	logic                 blocked;

	// direction and march length
	always_comb begin
		dx_in = $signed({1'b0, req.light_x}) - $signed({1'b0, req.point_x});
		dz_in = $signed({req.light_z[hlos_pkg::Z_W-1], req.light_z})
		      - $signed({req.point_z[hlos_pkg::Z_W-1], req.point_z});
		adx   = dx_q[CW] ? (CW+1)'(-dx_q) : dx_q;
		adz   = dz_q[12] ? 13'(-dz_q) : dz_q;
		adx_w = MW'(adx);
		adz_w = adz[MW-1:0];
		md_w  = (adx_w > adz_w) ? adx_w : adz_w;
	end

	// write address check
	always_comb begin
		wcol_wide = {{(XW-CW){1'b0}}, req.column};
		wcol_ok   = (wcol_wide < COL_LIMIT);
	end

	// per-axis quotients n*|d|/md
	hlos_step u_step_x (
		.clk (clk),
		.ctl (step_ctl),
		.num (adx_q),
		.md  (md_q),
		.q   (qx)
	);

	hlos_step u_step_z (
		.clk (clk),
		.ctl (step_ctl),
		.num (adz_q),
		.md  (md_q),
		.q   (qz)
	);

	// sample position, truncation toward zero
	always_comb begin
		col_sum  = xneg_q ? ({1'b0, px_q} - qx[CW:0]) : ({1'b0, px_q} + qx[CW:0]);
		col_wide = {{(XW-CW){1'b0}}, col_sum[CW-1:0]};
		z_smp    = zneg_q ? (pz_q - $signed({1'b0, qz})) : (pz_q + $signed({1'b0, qz}));
	end

	// blocked test on the sample read last cycle
	always_comb begin
		hgt     = inr_s1 ? rd_q : '0;
		surf    = $signed({2'b00, ground_q}) - $signed({{2{hgt[HW-1]}}, hgt});
		blocked = v_s1 && (surf < z_s1);
	end

	// next state and control
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = wcol_wide[AW-1:0];
		mem_wdata = req.height;
		issue     = 1'b0;
		res_set   = 1'b0;
		res_clr   = 1'b0;
		load_out  = 1'b0;
		step_ctl  = '0;
		req.ready = 1'b0;
		unique case (state_q)
			hlos_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == CLR_LAST) begin
					state_d = hlos_pkg::ST_IDLE;
				end
			end
			hlos_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.action == hlos_pkg::ACT_WRITE) begin
						mem_we = wcol_ok;
					end else begin
						state_d = hlos_pkg::ST_SETUP;
					end
				end
			end
			hlos_pkg::ST_SETUP: begin
				step_ctl.init = 1'b1;
				res_clr       = 1'b1;
				if (md_w == '0) begin
					state_d = hlos_pkg::ST_FIN;
				end else begin
					state_d = hlos_pkg::ST_RUN;
				end
			end
			hlos_pkg::ST_RUN: begin
				if (blocked) begin
					res_set = 1'b1;
					state_d = hlos_pkg::ST_FIN;
				end else begin
					issue        = 1'b1;
					step_ctl.adv = 1'b1;
					if (n_q == md_q - MW'(1)) begin
						state_d = hlos_pkg::ST_TAIL;
					end
				end
			end
			hlos_pkg::ST_TAIL: begin
				res_set = blocked;
				state_d = hlos_pkg::ST_FIN;
			end
			hlos_pkg::ST_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = hlos_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hlos_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hlos_pkg::ST_CLEAR;
			clr_q       <= '0;
			ground_q    <= hlos_pkg::GROUND_RESET;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hlos_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cfg_we) begin
				ground_q <= cfg_wdata;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issue;
		end
	end

	// query operands and march counters
	always_ff @(posedge clk) begin
		if (state_q == hlos_pkg::ST_IDLE && req.valid && req.action == hlos_pkg::ACT_QUERY) begin
			px_q <= req.point_x;
			pz_q <= $signed({req.point_z[hlos_pkg::Z_W-1], req.point_z});
			dx_q <= dx_in;
			dz_q <= dz_in;
		end
		if (state_q == hlos_pkg::ST_SETUP) begin
			adx_q  <= adx_w;
			adz_q  <= adz_w;
			md_q   <= md_w;
			xneg_q <= dx_q[CW];
			zneg_q <= dz_q[12];
			n_q    <= '0;
		end else if (issue) begin
			n_q <= n_q + MW'(1);
		end
		if (res_clr) begin
			res_q <= 1'b0;
		end else if (res_set) begin
			res_q <= 1'b1;
		end
		if (load_out) begin
			out_shadow_q <= res_q | res_set;
		end
		z_s1   <= z_smp;
		inr_s1 <= (col_wide < COL_LIMIT);
	end

	// height map: at most one write and one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[col_wide[AW-1:0]];
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.shadowed = out_shadow_q;

endmodule

FILE: tb/sv/hlos_shadow_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlos_shadow_checker
// Watches the request, response and configuration ports of the line-of-sight
// core. Keeps its own copy of the height map and ground level, works out the
// shadow flag of every accepted query and compares each response in order.
// ----------------------------------------------------------------------------
module hlos_shadow_checker
	import hlos_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	hlos_req_if              req,
	hlos_rsp_if              rsp,
	input  logic             cfg_we,
	input  logic [GND_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending_queries
);

	localparam int MAP_DEPTH = 1 << COL_W;

	logic        [GND_W-1:0] ground_level;
	logic signed [HGT_W-1:0] column_heights [MAP_DEPTH];
	bit                      expected_shadow_q [$];

	// walk from the surface point toward the light, stop at the first blocked sample
	function automatic bit predict_shadow(int px, int pz, int lx, int lz);
		int dx;
		int dz;
		int steps;
		int col;
		int z;
		dx = lx - px;
		dz = lz - pz;
		steps = (dx < 0) ? -dx : dx;
		if (((dz < 0) ? -dz : dz) > steps)
			steps = (dz < 0) ? -dz : dz;
		// light on the point gives no samples: lit
		for (int n = 0; n < steps; n++) begin
			col = px + (n * dx) / steps;
			z   = pz + (n * dz) / steps;
			if (int'(ground_level) - int'(column_heights[col[COL_W-1:0]]) < z)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// track configuration and map writes, queue predictions, check responses
	always @(posedge clk or negedge arst_n) begin : monitor
		bit want;
		if (!arst_n) begin
			ground_level = GROUND_RESET;
			foreach (column_heights[i])
				column_heights[i] = '0;
			expected_shadow_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				ground_level = cfg_wdata;
			// responses first, so a stray one never meets a query taken this edge
			if (rsp.valid && rsp.ready) begin
				if (expected_shadow_q.size() == 0) begin
					$error("shadowed: no query pending, got %0d", rsp.shadowed);
					fail_count++;
				end else begin
					want = expected_shadow_q.pop_front();
					if (rsp.shadowed !== want) begin
						$error("shadowed: expected %0d, got %0d", want, rsp.shadowed);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.action == ACT_WRITE)
					column_heights[req.column] = req.height;
				else
					expected_shadow_q.push_back(predict_shadow(int'(req.point_x),
						int'(req.point_z), int'(req.light_x), int'(req.light_z)));
			end
		end
		pending_queries = expected_shadow_q.size();
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives height writes and shadow queries into the line-of-sight core: a short
// directed set of edge cases, then random phases under several ground levels,
// with random request and response gaps and one long response hold-off.
// Checking is done by hlos_shadow_checker alongside the core.
// ----------------------------------------------------------------------------
module testbench;
	import hlos_pkg::*;

	localparam int PHASE_ITEMS  = 195;
	localparam int HOLD_CYCLES  = 2500;
	localparam int IDLE_LIMIT   = 40000;
	localparam int DRAIN_CYCLES = 3200;
	localparam int WINDOW       = 128;
	localparam int Z_MIN        = -1024;
	localparam int Z_MAX        = 2047;
	localparam int COL_MAX      = (1 << COL_W) - 1;

	typedef struct {
		logic                    action;
		logic        [COL_W-1:0] column;
		logic signed [HGT_W-1:0] height;
		logic        [COL_W-1:0] point_x;
		logic signed [Z_W-1:0]   point_z;
		logic        [COL_W-1:0] light_x;
		logic signed [Z_W-1:0]   light_z;
	} request_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [GND_W-1:0] cfg_wdata = '0;
	int               fail_count;
	int               pending_queries;
	int               ground_now = int'(GROUND_RESET);
	int               window_base = 0;
	bit               calm = 1'b0;
	bit               hold_request = 1'b0;
	int               quiet_cycles = 0;

	hlos_req_if req_ch ();
	hlos_rsp_if rsp_ch ();

	heightfield_line_of_sight_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	hlos_shadow_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.fail_count      (fail_count),
		.pending_queries (pending_queries)
	);

	always #2 clk = ~clk;

	// watchdog: too long without any request or response taken
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int clamp(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// ignored fields always carry random bits
	function automatic request_t noise_request();
		request_t r;
		r.action  = 1'($urandom_range(1));
		r.column  = COL_W'($urandom);
		r.height  = HGT_W'($urandom);
		r.point_x = COL_W'($urandom);
		r.point_z = Z_W'(int'($urandom_range(Z_MAX - Z_MIN)) + Z_MIN);
		r.light_x = COL_W'($urandom);
		r.light_z = Z_W'(int'($urandom_range(Z_MAX - Z_MIN)) + Z_MIN);
		return r;
	endfunction

	function automatic request_t write_req(int col, int h);
		request_t r;
		r = noise_request();
		r.action = ACT_WRITE;
		r.column = COL_W'(col);
		r.height = HGT_W'(h);
		return r;
	endfunction

	function automatic request_t query_req(int px, int pz, int lx, int lz);
		request_t r;
		r = noise_request();
		r.action  = ACT_QUERY;
		r.point_x = COL_W'(px);
		r.point_z = Z_W'(pz);
		r.light_x = COL_W'(lx);
		r.light_z = Z_W'(lz);
		return r;
	endfunction

	// mostly short lines in a small window of columns, depths near the ground
	function automatic request_t random_request();
		int px;
		int pz;
		if ($urandom_range(99) < 10)
			return noise_request();
		if ($urandom_range(99) < 45)
			return write_req(window_base + int'($urandom_range(WINDOW - 1)),
				int'($urandom_range(200)) - 100);
		px = window_base + int'($urandom_range(WINDOW - 1));
		pz = clamp(ground_now + int'($urandom_range(150)) - 110, Z_MIN, Z_MAX);
		return query_req(px, pz,
			clamp(px + int'($urandom_range(80)) - 40, 0, COL_MAX),
			clamp(pz + int'($urandom_range(96)) - 48, Z_MIN, Z_MAX));
	endfunction

	// offer one request from a falling edge, return at the falling edge after it is taken
	task automatic send(request_t r);
		while (!calm && $urandom_range(99) < 22) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.action  <= r.action;
		req_ch.column  <= r.column;
		req_ch.height  <= r.height;
		req_ch.point_x <= r.point_x;
		req_ch.point_z <= r.point_z;
		req_ch.light_x <= r.light_x;
		req_ch.light_z <= r.light_z;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	// ground level changes only once the core has gone idle
	task automatic set_ground(int level);
		req_ch.valid <= 1'b0;
		while (pending_queries != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= GND_W'(level);
		ground_now = level;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// response side: random back-pressure, one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				rsp_ch.ready <= calm || ($urandom_range(99) >= 22);
			end
		end
	end

	// stimulus and verdict
	initial begin
		request_t edge_cases [$];
		int       levels [6];

		req_ch.valid   = 1'b0;
		req_ch.action  = ACT_WRITE;
		req_ch.column  = '0;
		req_ch.height  = '0;
		req_ch.point_x = '0;
		req_ch.point_z = '0;
		req_ch.light_x = '0;
		req_ch.light_z = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// light on the point, longest lines both ways, a point below everything
		edge_cases.push_back(query_req(5, 100, 5, 100));
		edge_cases.push_back(query_req(0, Z_MIN, COL_MAX, Z_MAX));
		edge_cases.push_back(query_req(COL_MAX, Z_MAX, 0, Z_MIN));
		edge_cases.push_back(query_req(0, Z_MAX, 10, Z_MAX));
		// extreme heights and alternating bit patterns
		edge_cases.push_back(write_req(0, 1023));
		edge_cases.push_back(write_req(COL_MAX, -1024));
		edge_cases.push_back(write_req(512, -1));
		edge_cases.push_back(write_req(341, 682));
		edge_cases.push_back(write_req(682, -683));
		// samples just either side of a column surface
		edge_cases.push_back(query_req(0, -800, 5, -800));
		edge_cases.push_back(query_req(0, -830, 5, -830));
		edge_cases.push_back(query_req(COL_MAX, 1200, 1020, 1200));
		edge_cases.push_back(query_req(COL_MAX, 1230, COL_MAX, 1231));
		edge_cases.push_back(query_req(COL_MAX, 1220, COL_MAX, 1221));
		edge_cases.push_back(query_req(500, 0, 520, 100));
		edge_cases.push_back(query_req(10, 300, 12, 0));
		edge_cases.push_back(query_req(341, -490, 341, -480));
		edge_cases.push_back(query_req(680, 880, 685, 880));

		@(negedge clk);
		foreach (edge_cases[i])
			send(edge_cases[i]);

		levels[0] = 0;
		levels[1] = (1 << GND_W) - 1;
		levels[2] = int'($urandom_range((1 << GND_W) - 1));
		levels[3] = 1024;
		levels[4] = int'($urandom_range((1 << GND_W) - 1));
		levels[5] = int'(GROUND_RESET);

		foreach (levels[p]) begin
			set_ground(levels[p]);
			window_base = int'($urandom_range(COL_MAX + 1 - WINDOW));
			calm = (p == 3);
			// fill the core while responses are held off
			if (p == 2)
				hold_request = 1'b1;
			repeat (PHASE_ITEMS)
				send(random_request());
		end
		req_ch.valid <= 1'b0;

		while (pending_queries != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending_queries == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: heightfield_line_of_sight_core.f
rtl/hlos_pkg.sv
rtl/hlos_req_if.sv
rtl/hlos_rsp_if.sv
rtl/hlos_step.sv
rtl/heightfield_line_of_sight_core.sv
tb/sv/hlos_shadow_checker.sv
tb/sv/testbench.sv
